FILE: hdl/qau_pkg.sv
// Shared opcode and status codes for the quaternion arithmetic unit.
`default_nettype none
package qau_pkg;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_SCALE   = 4'd4,
		OP_EQUAL   = 4'd5,
		OP_CONJ    = 4'd6,
		OP_NORMSQ  = 4'd7,
		OP_INVERSE = 4'd8,
		OP_ROTATE  = 4'd9
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_NE  = 2'd1,
		ST_BAD = 2'd2
	} status_t;

endpackage
`default_nettype wire

FILE: hdl/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit: fully pipelined, one request per cycle while the output is not held.
// Every opcode takes the same path, through the bit-per-stage restoring divider that runs
// in parallel with the other paths; their results travel alongside its stages.
// Throughput is one request per cycle unless a result waits; then the whole pipeline holds.
// Reset clears only the valid bits; the data registers are not reset.
`default_nettype none
module quaternion_arithmetic_unit
	import qau_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_value
	input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	// opcode
	input  wire logic [3:0] s_tuser,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// r_w, r_x, r_y, r_z, norm_square
	output logic [((5*DATA_WIDTH-1+7)/8)*8-1:0] m_tdata,
	// status
	output logic [1:0] m_tuser
);

	localparam int DW    = DATA_WIDTH;
	localparam int FB    = FRAC_BITS;
	localparam int OUT_W = ((5*DW-1+7)/8)*8;
	localparam int OW    = DW + 1;
	localparam int PW    = 2 * OW;
	localparam int SPW   = PW - FB;
	localparam int HW    = SPW + 2;
	localparam int NW    = HW + FB;
	localparam int CW    = NW + DW;

	localparam logic signed [HW-1:0] SMAXH = {{(HW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [HW-1:0] SMINH = {{(HW-DW+1){1'b1}}, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	typedef logic [3:0][3:0][SPW-1:0] prod_t;
	typedef logic [3:0][HW-1:0] hsum_t;
	typedef logic [3:0][DW-1:0] quad_t;
	typedef struct packed {
		quad_t        r;
		status_t      st;
		logic [DW-2:0] ns;
		logic         dv;
	} side_t;

	function automatic logic signed [HW-1:0] sx(input logic [SPW-1:0] v);
		return HW'($signed(v));
	endfunction

	function automatic hsum_t ham(input prod_t p);
		hsum_t r;
		r[0] = sx(p[0][0]) - sx(p[1][1]) - sx(p[2][2]) - sx(p[3][3]);
		r[1] = sx(p[0][1]) + sx(p[1][0]) + sx(p[2][3]) - sx(p[3][2]);
		r[2] = sx(p[0][2]) - sx(p[1][3]) + sx(p[2][0]) + sx(p[3][1]);
		r[3] = sx(p[0][3]) + sx(p[1][2]) - sx(p[2][1]) + sx(p[3][0]);
		return r;
	endfunction

	function automatic logic [DW-1:0] sat(input logic signed [HW-1:0] v);
		if (v > SMAXH) begin
			return SMAX;
		end else if (v < SMINH) begin
			return SMIN;
		end
		return v[DW-1:0];
	endfunction

	logic en;

	// Stage 1: input registers.
	logic vld_s1;
	logic [3:0] op_s1;
	logic signed [DW-1:0] a_s1 [4];
	logic signed [DW-1:0] b_s1 [4];
	logic signed [DW-1:0] sc_s1;

	// Stage 2: products.
	logic vld_s2;
	logic [3:0] op_s2;
	logic signed [DW-1:0] a_s2 [4];
	logic signed [DW-1:0] b_s2 [4];
	prod_t hp_s2;
	logic [3:0][SPW-1:0] sp_s2, nap_s2, nbp_s2;

	// Stage 3: sums and direct results.
	logic vld_s3;
	logic [3:0] op_s3;
	quad_t rdir_s3;
	status_t st_s3;
	logic [DW-2:0] ns_s3;
	hsum_t num_s3;
	logic [HW-1:0] den_s3;
	quad_t ts_s3;
	logic signed [OW-1:0] ca_s3 [4];

	// Stage 4: rotation products and divider setup.
	logic vld_s4;
	logic [3:0] op_s4;
	quad_t rdir_s4;
	status_t st_s4;
	logic [DW-2:0] ns_s4;
	prod_t rp_s4;
	logic [3:0][NW-1:0] rem_s4;
	logic [3:0] neg_s4;
	logic [HW-1:0] den_s4;

	// Divider stages, one quotient bit each.
	logic dv_vld_sd [DW];
	logic [3:0][NW-1:0] dv_rem_sd [DW];
	quad_t dv_q_sd [DW];
	logic [HW-1:0] dv_den_sd [DW];
	logic [3:0] dv_neg_sd [DW];
	side_t dv_side_sd [DW];

	// Output register.
	logic out_vld_q;
	quad_t out_r_q;
	status_t out_st_q;
	logic [DW-2:0] out_ns_q;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_vld_q <= dv_vld_sd[DW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= s_tuser;
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= s_tdata[i*DW +: DW];
				b_s1[i] <= s_tdata[(i+4)*DW +: DW];
			end
			sc_s1 <= s_tdata[8*DW +: DW];
		end
	end

	logic signed [OW-1:0] pa [4];
	logic signed [OW-1:0] pb [4];
	logic signed [OW-1:0] qop [4];
	logic signed [OW-1:0] psc;
	logic signed [PW-1:0] hfull [4][4];
	logic signed [PW-1:0] sfull [4];
	logic signed [PW-1:0] nafull [4];
	logic signed [PW-1:0] nbfull [4];

	always_comb begin
		psc = OW'(sc_s1);
		for (int i = 0; i < 4; i++) begin
			pa[i] = OW'(a_s1[i]);
			pb[i] = OW'(b_s1[i]);
		end
		case (op_s1)
			OP_DIV: begin
				qop[0] = pb[0];
				for (int i = 1; i < 4; i++) qop[i] = -pb[i];
			end
			OP_ROTATE: begin
				qop[0] = '0;
				for (int i = 1; i < 4; i++) qop[i] = pb[i];
			end
			default: begin
				for (int i = 0; i < 4; i++) qop[i] = pb[i];
			end
		endcase
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) hfull[i][j] = pa[i] * qop[j];
			sfull[i]  = pa[i] * psc;
			nafull[i] = pa[i] * pa[i];
			nbfull[i] = pb[i] * pb[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			for (int i = 0; i < 4; i++) begin
				a_s2[i] <= a_s1[i];
				b_s2[i] <= b_s1[i];
				for (int j = 0; j < 4; j++) hp_s2[i][j] <= hfull[i][j][PW-1:FB];
				sp_s2[i]  <= sfull[i][PW-1:FB];
				nap_s2[i] <= nafull[i][PW-1:FB];
				nbp_s2[i] <= nbfull[i][PW-1:FB];
			end
		end
	end

	hsum_t h2;
	logic signed [HW-1:0] na2, nb2;
	quad_t rdir2;
	status_t st2;
	hsum_t num2;
	logic equal2;

	always_comb begin
		h2     = ham(hp_s2);
		na2    = sx(nap_s2[0]) + sx(nap_s2[1]) + sx(nap_s2[2]) + sx(nap_s2[3]);
		nb2    = sx(nbp_s2[0]) + sx(nbp_s2[1]) + sx(nbp_s2[2]) + sx(nbp_s2[3]);
		rdir2  = '0;
		st2    = ST_OK;
		equal2 = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (a_s2[i] != b_s2[i]) equal2 = 1'b0;
		end
		num2[0] = HW'(a_s2[0]);
		for (int i = 1; i < 4; i++) num2[i] = -HW'(a_s2[i]);
		case (op_s2)
			OP_ADD: begin
				for (int i = 0; i < 4; i++) rdir2[i] = sat(HW'(a_s2[i]) + HW'(b_s2[i]));
			end
			OP_SUB: begin
				for (int i = 0; i < 4; i++) rdir2[i] = sat(HW'(a_s2[i]) - HW'(b_s2[i]));
			end
			OP_MUL: begin
				for (int i = 0; i < 4; i++) rdir2[i] = sat($signed(h2[i]));
			end
			OP_DIV: begin
				num2 = h2;
				if (nb2 == '0) st2 = ST_BAD;
			end
			OP_SCALE: begin
				for (int i = 0; i < 4; i++) rdir2[i] = sat(sx(sp_s2[i]));
			end
			OP_EQUAL: begin
				st2 = equal2 ? ST_OK : ST_NE;
			end
			OP_CONJ: begin
				rdir2[0] = a_s2[0];
				for (int i = 1; i < 4; i++) rdir2[i] = sat(-HW'(a_s2[i]));
			end
			OP_NORMSQ: begin
				st2 = ST_OK;
			end
			OP_INVERSE: begin
				if (na2 == '0) st2 = ST_BAD;
			end
			OP_ROTATE: begin
				st2 = ST_OK;
			end
			default: begin
				st2 = ST_BAD;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3   <= op_s2;
			rdir_s3 <= rdir2;
			st_s3   <= st2;
			ns_s3   <= (na2 > SMAXH) ? {(DW-1){1'b1}} : na2[DW-2:0];
			num_s3  <= num2;
			den_s3  <= (op_s2 == OP_DIV) ? nb2 : na2;
			ca_s3[0] <= OW'(a_s2[0]);
			for (int i = 0; i < 4; i++) begin
				ts_s3[i] <= sat($signed(h2[i]));
				if (i > 0) ca_s3[i] <= -OW'(a_s2[i]);
			end
		end
	end

	logic signed [PW-1:0] rfull [4][4];
	logic signed [OW-1:0] tse [4];
	logic [3:0][NW-1:0] rem3;
	logic [3:0] neg3;
	logic [HW-1:0] mag3 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tse[i] = OW'($signed(ts_s3[i]));
			for (int j = 0; j < 4; j++) rfull[i][j] = tse[i] * ca_s3[j];
			neg3[i] = num_s3[i][HW-1];
			mag3[i] = neg3[i] ? (~num_s3[i] + 1'b1) : num_s3[i];
			rem3[i] = {mag3[i], {FB{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4   <= op_s3;
			rdir_s4 <= rdir_s3;
			st_s4   <= st_s3;
			ns_s4   <= ns_s3;
			rem_s4  <= rem3;
			neg_s4  <= neg3;
			den_s4  <= den_s3;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) rp_s4[i][j] <= rfull[i][j][PW-1:FB];
			end
		end
	end

	hsum_t rot4;
	side_t side0;

	always_comb begin
		rot4     = ham(rp_s4);
		side0.st = st_s4;
		side0.ns = ns_s4;
		side0.dv = (op_s4 == OP_DIV) || (op_s4 == OP_INVERSE);
		side0.r  = rdir_s4;
		if (op_s4 == OP_ROTATE) begin
			side0.r[0] = '0;
			for (int i = 1; i < 4; i++) side0.r[i] = sat($signed(rot4[i]));
		end
	end

	for (genvar t = 0; t < DW; t++) begin : g_div
		localparam int B = DW - 1 - t;
		logic vin;
		logic [3:0][NW-1:0] rin, rnx;
		quad_t qin, qnx;
		logic [HW-1:0] din;
		logic [3:0] nin;
		side_t sin;
		logic [CW-1:0] dsh;

		if (t == 0) begin : g_first
			assign vin = vld_s4;
			assign rin = rem_s4;
			assign qin = '0;
			assign din = den_s4;
			assign nin = neg_s4;
			assign sin = side0;
		end else begin : g_next
			assign vin = dv_vld_sd[t-1];
			assign rin = dv_rem_sd[t-1];
			assign qin = dv_q_sd[t-1];
			assign din = dv_den_sd[t-1];
			assign nin = dv_neg_sd[t-1];
			assign sin = dv_side_sd[t-1];
		end

		always_comb begin
			dsh = CW'(din) << B;
			rnx = rin;
			qnx = qin;
			for (int i = 0; i < 4; i++) begin
				if (CW'(rin[i]) >= dsh) begin
					rnx[i]    = rin[i] - dsh[NW-1:0];
					qnx[i][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_sd[t] <= 1'b0;
			end else if (en) begin
				dv_vld_sd[t] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_sd[t]  <= rnx;
				dv_q_sd[t]    <= qnx;
				dv_den_sd[t]  <= din;
				dv_neg_sd[t]  <= nin;
				dv_side_sd[t] <= sin;
			end
		end
	end

	quad_t rfin;

	always_comb begin
		rfin = dv_side_sd[DW-1].r;
		if (dv_side_sd[DW-1].dv && dv_side_sd[DW-1].st == ST_OK) begin
			for (int i = 0; i < 4; i++) begin
				if (dv_q_sd[DW-1][i][DW-1]) begin
					rfin[i] = dv_neg_sd[DW-1][i] ? SMIN : SMAX;
				end else begin
					rfin[i] = dv_neg_sd[DW-1][i] ? (~dv_q_sd[DW-1][i] + 1'b1)
						: dv_q_sd[DW-1][i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_r_q  <= rfin;
			out_st_q <= dv_side_sd[DW-1].st;
			out_ns_q <= dv_side_sd[DW-1].ns;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_W'({out_ns_q, out_r_q[3], out_r_q[2], out_r_q[1], out_r_q[0]});
	assign m_tuser  = out_st_q;

	a_bad_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_st_q == ST_BAD |-> out_r_q == '0)
		else $error("bad-argument result is not zero");

	a_ne_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_st_q == ST_NE |-> out_r_q == '0)
		else $error("equality result is not zero");

	a_div_rem : assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_sd[DW-1] && dv_side_sd[DW-1].dv && dv_den_sd[DW-1] != '0
		&& !dv_q_sd[DW-1][0][DW-1]
		|-> dv_rem_sd[DW-1][0] < NW'(dv_den_sd[DW-1]))
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

FILE: dv/quaternion_arithmetic_unit_checker.sv
// Checker for the quaternion arithmetic unit: predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_arithmetic_unit_checker
	import qau_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [287:0] s_tdata,
	input  wire logic [3:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [159:0] m_tdata,
	input  wire logic [1:0]   m_tuser,
	output int                errors,
	output int                pending
);

	localparam int FRAC = 16;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] w;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [30:0] nsq;
		logic [1:0]  st;
	} quat_result_t;

	typedef longint quat_t [4];

	quat_result_t expected_results [$];

	function automatic longint clamp32(longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	// Arithmetic shift floors toward minus infinity.
	function automatic longint fx_mul(longint p, longint q);
		longint prod;
		prod = p * q;
		return prod >>> FRAC;
	endfunction

	function automatic quat_t hamilton(quat_t p, quat_t q);
		quat_t r;
		r[0] = fx_mul(p[0], q[0]) - fx_mul(p[1], q[1]) - fx_mul(p[2], q[2]) - fx_mul(p[3], q[3]);
		r[1] = fx_mul(p[0], q[1]) + fx_mul(p[1], q[0]) + fx_mul(p[2], q[3]) - fx_mul(p[3], q[2]);
		r[2] = fx_mul(p[0], q[2]) - fx_mul(p[1], q[3]) + fx_mul(p[2], q[0]) + fx_mul(p[3], q[1]);
		r[3] = fx_mul(p[0], q[3]) + fx_mul(p[1], q[2]) - fx_mul(p[2], q[1]) + fx_mul(p[3], q[0]);
		return r;
	endfunction

	function automatic longint norm_sq(quat_t p);
		return fx_mul(p[0], p[0]) + fx_mul(p[1], p[1]) + fx_mul(p[2], p[2]) + fx_mul(p[3], p[3]);
	endfunction

	function automatic longint fx_div(longint num, longint den);
		logic neg;
		longint unsigned mag, ip, rem, res;
		neg = num < 0;
		mag = neg ? -num : num;
		ip = mag / den;
		rem = mag % den;
		if ((ip >> (31 - FRAC)) != 0) return neg ? SMIN : SMAX;
		res = (ip << FRAC) + ((rem << FRAC) / den);
		if (neg) return (res > 64'd2147483648) ? SMIN : -longint'(res);
		return (res > 64'd2147483647) ? SMAX : longint'(res);
	endfunction

	function automatic quat_result_t predict_quat(logic [3:0] op, logic [287:0] d);
		quat_t a, b, r, t, c;
		longint s, na, nb;
		quat_result_t e;
		logic [1:0] st;
		st = ST_OK;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(d[32*i +: 32]));
			b[i] = longint'($signed(d[32*(i+4) +: 32]));
			r[i] = 0;
		end
		s = longint'($signed(d[256 +: 32]));
		na = norm_sq(a);
		case (op)
			OP_ADD: for (int i = 0; i < 4; i++) r[i] = clamp32(a[i] + b[i]);
			OP_SUB: for (int i = 0; i < 4; i++) r[i] = clamp32(a[i] - b[i]);
			OP_MUL: begin
				t = hamilton(a, b);
				for (int i = 0; i < 4; i++) r[i] = clamp32(t[i]);
			end
			OP_DIV: begin
				nb = norm_sq(b);
				if (nb == 0) begin
					st = ST_BAD;
				end else begin
					c[0] = b[0]; c[1] = -b[1]; c[2] = -b[2]; c[3] = -b[3];
					t = hamilton(a, c);
					for (int i = 0; i < 4; i++) r[i] = fx_div(t[i], nb);
				end
			end
			OP_SCALE: for (int i = 0; i < 4; i++) r[i] = clamp32(fx_mul(a[i], s));
			OP_EQUAL: st = (a == b) ? ST_OK : ST_NE;
			OP_CONJ: begin
				r[0] = a[0];
				for (int i = 1; i < 4; i++) r[i] = clamp32(-a[i]);
			end
			OP_NORMSQ: ;
			OP_INVERSE: begin
				if (na == 0) begin
					st = ST_BAD;
				end else begin
					r[0] = fx_div(a[0], na);
					for (int i = 1; i < 4; i++) r[i] = fx_div(-a[i], na);
				end
			end
			OP_ROTATE: begin
				c[0] = 0; c[1] = b[1]; c[2] = b[2]; c[3] = b[3];
				t = hamilton(a, c);
				for (int i = 0; i < 4; i++) t[i] = clamp32(t[i]);
				c[0] = a[0]; c[1] = -a[1]; c[2] = -a[2]; c[3] = -a[3];
				r = hamilton(t, c);
				r[0] = 0;
				for (int i = 1; i < 4; i++) r[i] = clamp32(r[i]);
			end
			default: st = ST_BAD;
		endcase
		e.w = r[0][31:0];
		e.x = r[1][31:0];
		e.y = r[2][31:0];
		e.z = r[3][31:0];
		e.nsq = (na > SMAX) ? 31'h7FFFFFFF : na[30:0];
		e.st = st;
		return e;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		quat_result_t exp_r, got;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_quat(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
					m_tdata[158:128], m_tuser};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.w !== got.w || exp_r.x !== got.x || exp_r.y !== got.y ||
						exp_r.z !== got.z || exp_r.nsq !== got.nsq || exp_r.st !== got.st) begin
						$display("%0t: mismatch expected w=%h x=%h y=%h z=%h n=%h st=%0d",
							$time, exp_r.w, exp_r.x, exp_r.y, exp_r.z, exp_r.nsq, exp_r.st);
						$display("%0t:          actual w=%h x=%h y=%h z=%h n=%h st=%0d",
							$time, got.w, got.x, got.y, got.z, got.nsq, got.st);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: dv/quaternion_arithmetic_unit_tb.sv
// Testbench top for the quaternion arithmetic unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_arithmetic_unit_tb;
	import qau_pkg::*;

	localparam int RANDOM_REQUESTS = 600;
	localparam longint CYCLE_LIMIT = 200000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [287:0] s_tdata = '0;
	logic [3:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;
	logic [1:0]   m_tuser;
	int           errors;
	int           pending;
	longint       cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	quaternion_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	quaternion_arithmetic_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The receiver stalls in runs whose lengths change over the run, some with no stall at all.
	always @(posedge clk) begin
		int phase;
		phase = int'((cycles / 500) % 4);
		case (phase)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 1) != 0);
			default: m_tready <= ((cycles % 23) < 15);
		endcase
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h00000000;
			3: return 32'h00010000 * $urandom_range(0, 8) - 32'h00040000;
			4: return $urandom_range(0, 3) - 2;
			5, 6: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
			7: return $urandom_range(0, 32'hFFFFFF) - 32'h800000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_quat(logic [3:0] op, logic [287:0] d);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_random(logic [3:0] op);
		logic [287:0] d;
		for (int i = 0; i < 9; i++) d[32*i +: 32] = pick_value();
		if (op == OP_EQUAL && $urandom_range(0, 1)) d[255:128] = d[127:0];
		send_quat(op, d);
	endtask

	initial begin
		int gap;
		int burst;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every opcode on extremes, zero-norm divisors and unused opcodes.
		send_quat(OP_ADD, {9{32'h7FFFFFFF}});
		send_quat(OP_SUB, {{5{32'h7FFFFFFF}}, {4{32'h80000000}}});
		send_quat(OP_MUL, {9{32'h80000000}});
		send_quat(OP_MUL, {9{32'h00010000}});
		send_quat(OP_DIV, {32'h0, {4{32'h0}}, {4{32'h00010000}}});
		send_quat(OP_DIV, {32'h0, {4{32'h00000001}}, {4{32'h00020000}}});
		send_quat(OP_DIV, {32'h0, {4{32'h00000010}}, {4{32'h7FFFFFFF}}});
		send_quat(OP_SCALE, {32'h80000000, 128'h0, {4{32'h80000000}}});
		send_quat(OP_SCALE, {32'hFFFF8000, 128'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h3});
		send_quat(OP_EQUAL, {32'h0, {2{128'h0123456789ABCDEF_FEDCBA9876543210}}});
		send_quat(OP_EQUAL, {32'h0, 128'h1, 128'h0});
		send_quat(OP_CONJ, {32'h0, 128'h0, {4{32'h80000000}}});
		send_quat(OP_NORMSQ, {32'h0, 128'h0, {4{32'h7FFFFFFF}}});
		send_quat(OP_NORMSQ, {32'h0, 128'h0, {4{32'h00008000}}});
		send_quat(OP_INVERSE, {32'h0, 128'h0, 128'h0});
		send_quat(OP_INVERSE, {32'h0, 128'h0, {4{32'h000000FF}}});
		send_quat(OP_INVERSE, {32'h0, 128'h0, 32'h0, 32'h0, 32'h0, 32'h00020000});
		send_quat(OP_ROTATE, {32'h0, {4{32'h7FFFFFFF}}, {4{32'h7FFFFFFF}}});
		send_quat(OP_ROTATE, {32'h0, 32'h00010000, 32'h00020000, 32'h00030000, 32'h5,
			32'h0, 32'h0, 32'h0, 32'h00010000});
		for (int op = 10; op < 16; op++) send_quat(4'(op), {9{32'hA5A5A5A5}});
		send_quat(OP_ADD, {9{32'hFFFFFFFF}});

		for (int n = 0; n < RANDOM_REQUESTS; ) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst && n < RANDOM_REQUESTS; k++, n++)
				send_random(($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
					: 4'($urandom_range(0, 9)));
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
